// ----- rtl/swm_pkg.sv -----
// ============================================================================
// swm_pkg
// Shared constants, types and cell link structures for the running median
// filter.
// ============================================================================
package swm_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int IDX_BITS    = $clog2(WINDOW_MAX);
    localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);
    localparam int HALF_MAX    = WINDOW_MAX / 2;
    localparam int MID_BITS    = (HALF_MAX > 1) ? $clog2(HALF_MAX) : 1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [IDX_BITS-1:0]           age_t;
    typedef logic [CNT_BITS-1:0]           cnt_t;

    // what a cell shows its neighbors
    typedef struct packed {
        sample_t value;
        age_t    age;
        logic    le_key;
    } swm_link_t;

    // broadcast to every cell
    typedef struct packed {
        logic    en;
        logic    full;
        sample_t key;
        age_t    oldest_age;
    } swm_bcast_t;

endpackage

// ----- rtl/swm_sample_if.sv -----
// ============================================================================
// swm_sample_if
// Valid/ready channel carrying one sample request.
// ============================================================================
interface swm_sample_if
    import swm_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ----- rtl/swm_median_if.sv -----
// ============================================================================
// swm_median_if
// Valid/ready channel carrying one median result request.
// ============================================================================
interface swm_median_if
    import swm_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

// ----- rtl/sliding_window_median_unit.sv -----
// ============================================================================
// sliding_window_median_unit
// Running lower median over a sliding window of up to WINDOW_MAX samples.
// ============================================================================
// Takes one sample per clock unless a pending result waits for the output
// register. The window is a row of WINDOW_MAX cells kept in ascending order;
// on each accepted sample every cell evicts, shifts or inserts at once, so
// the cycle time is set by the evict and insert ripple along the row. Once
// the window has seen K samples each sample yields the rank (K-1)/2 element,
// held pending, then put in the output register. Writing the window size
// restarts the fill; size 0 acts as 1 and sizes above WINDOW_MAX saturate.
module sliding_window_median_unit
    import swm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CNT_BITS-1:0] cfg_wdata,
    swm_sample_if.sink          sample_ch,
    swm_median_if.source        median_ch
);

    logic [IDX_BITS-1:0] km1_reg;
    logic [IDX_BITS-1:0] km1_next;
    cnt_t                fill_reg;
    cnt_t                fill_next;
    logic                pend_reg;
    logic                pend_next;

    cnt_t                win_len;
    logic                full;
    logic                accept;
    logic                produce;
    logic                take;
    swm_bcast_t          bc;

    swm_link_t           links [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] rem_vec;
    logic [WINDOW_MAX-1:0] le_vec;
    logic [WINDOW_MAX-1:0] old_vec;
    sample_t             low_vals [HALF_MAX];

    assign win_len = cnt_t'(km1_reg) + cnt_t'(1);
    assign full    = (fill_reg == win_len);
    assign accept  = sample_ch.valid && sample_ch.ready;
    assign produce = full || ((fill_reg + cnt_t'(1)) == win_len);

    assign sample_ch.ready = !pend_reg || take;

    assign bc.en         = accept;
    assign bc.full       = full;
    assign bc.key        = sample_ch.sample;
    assign bc.oldest_age = km1_reg;

    always_comb
    begin
        if (cfg_wdata == '0)
            km1_next = '0;
        else if (cfg_wdata > cnt_t'(WINDOW_MAX))
            km1_next = IDX_BITS'(WINDOW_MAX - 1);
        else
            km1_next = IDX_BITS'(cfg_wdata - cnt_t'(1));
    end

    always_comb
    begin
        if (cfg_we)
            fill_next = '0;
        else if (accept && !full)
            fill_next = fill_reg + cnt_t'(1);
        else
            fill_next = fill_reg;

        if (accept)
            pend_next = produce;
        else if (take)
            pend_next = 1'b0;
        else
            pend_next = pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            km1_reg  <= '0;
            fill_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                km1_reg <= km1_next;
            fill_reg <= fill_next;
            pend_reg <= pend_next;
        end
    end

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        swm_link_t prev_l;
        swm_link_t next_l;
        logic      nvalid;
        logic      rin;
        logic      lin;

        if (i == 0)
        begin : g_first
            assign prev_l = '0;
            assign rin    = 1'b0;
            assign lin    = 1'b1;
        end
        else
        begin : g_mid
            assign prev_l = links[i-1];
            assign rin    = rem_vec[i-1];
            assign lin    = le_vec[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_last
            assign next_l = '0;
            assign nvalid = 1'b0;
        end
        else
        begin : g_inner
            assign next_l = links[i+1];
            assign nvalid = (fill_reg > cnt_t'(i + 1));
        end

        swm_cell u_cell (
            .clk        (clk),
            .bc         (bc),
            .valid      (fill_reg > cnt_t'(i)),
            .next_valid (nvalid),
            .prev_link  (prev_l),
            .next_link  (next_l),
            .rem_in     (rin),
            .le_in      (lin),
            .link       (links[i]),
            .rem_out    (rem_vec[i]),
            .le_out     (le_vec[i]),
            .oldest     (old_vec[i])
        );

        if (i < HALF_MAX)
        begin : g_low
            assign low_vals[i] = links[i].value;
        end
    end

    swm_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .vals      (low_vals),
        .mid       (MID_BITS'(km1_reg >> 1)),
        .pend      (pend_reg),
        .out_ready (median_ch.ready),
        .out_valid (median_ch.valid),
        .median    (median_ch.median),
        .take      (take)
    );

    // fill never runs past the window length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= win_len)
        else $error("fill count beyond window length");

    // a full window has exactly one entry to evict
    a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> $onehot(old_vec))
        else $error("full window without a unique oldest entry");

    a_no_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        !full |-> (old_vec == '0))
        else $error("eviction flagged while window is filling");

    // a result only leaves after the window held one
    a_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(median_ch.valid) |-> $past(pend_reg))
        else $error("median issued without a pending result");

endmodule

// ----- rtl/swm_cell.sv -----
// ============================================================================
// swm_cell
// One slot of the sorted window. Holds a value and its age, and on each
// request takes its new contents from itself, a neighbor or the new sample.
// ============================================================================
module swm_cell
    import swm_pkg::*;
(
    input  logic       clk,
    input  swm_bcast_t bc,
    input  logic       valid,
    input  logic       next_valid,
    input  swm_link_t  prev_link,
    input  swm_link_t  next_link,
    input  logic       rem_in,
    input  logic       le_in,
    output swm_link_t  link,
    output logic       rem_out,
    output logic       le_out,
    output logic       oldest
);

    sample_t value_reg;
    sample_t value_next;
    age_t    age_reg;
    age_t    age_next;

    logic    cvalid;
    logic    cur_cmp;
    sample_t cur_v;
    age_t    cur_a;
    sample_t prv_v;
    age_t    prv_a;

    assign link.value  = value_reg;
    assign link.age    = age_reg;
    assign link.le_key = (value_reg <= bc.key);

    assign oldest  = valid && bc.full && (age_reg == bc.oldest_age);
    assign rem_out = rem_in || oldest;

    // window after eviction, as seen at this slot and the one before
    assign cvalid  = bc.full ? next_valid : valid;
    assign cur_v   = rem_out ? next_link.value : value_reg;
    assign cur_a   = rem_out ? next_link.age : age_reg;
    assign cur_cmp = rem_out ? next_link.le_key : link.le_key;
    assign prv_v   = rem_in ? value_reg : prev_link.value;
    assign prv_a   = rem_in ? age_reg : prev_link.age;

    assign le_out  = cvalid && cur_cmp;

    always_comb
    begin
        if (le_out)
        begin
            value_next = cur_v;
            age_next   = cur_a + age_t'(1);
        end
        else if (le_in)
        begin
            value_next = bc.key;
            age_next   = '0;
        end
        else
        begin
            value_next = prv_v;
            age_next   = prv_a + age_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (bc.en)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule

// ----- rtl/swm_out_stage.sv -----
// ============================================================================
// swm_out_stage
// Picks the lower median out of the sorted window and holds it in the
// output register until the sink takes it.
// ============================================================================
module swm_out_stage
    import swm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  sample_t             vals [HALF_MAX],
    input  logic [MID_BITS-1:0] mid,
    input  logic                pend,
    input  logic                out_ready,
    output logic                out_valid,
    output sample_t             median,
    output logic                take
);

    logic    out_valid_reg;
    logic    out_valid_next;
    sample_t median_reg;

    assign take      = pend && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign median    = median_reg;

    always_comb
    begin
        if (take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            median_reg <= vals[mid];
    end

endmodule
